// ===== sv/bael_pkg.sv =====
package bael_pkg;

    localparam int unsigned SIZE_W = 16;
    localparam logic [SIZE_W-1:0] HEAP_SIZE_RESET = 16'h8000;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_REALLOC,
        OP_RESERVED
    } op_t;

    typedef enum logic [2:0] {
        ERR_OK,
        ERR_ZERO_SIZE,
        ERR_HEAP_EXHAUSTED,
        ERR_NO_SLOT,
        ERR_INVALID_PTR,
        ERR_REALLOC_NOT_FOUND
    } err_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE
    } state_t;

    typedef struct packed {
        logic              live;
        logic              free_seen;
        logic              match_seen;
        logic [SIZE_W-1:0] match_size;
    } scan_token_t;

    typedef struct packed {
        logic claim;
        logic drop;
    } commit_t;

endpackage

// ===== sv/bael_cell.sv =====
module bael_cell
    import bael_pkg::*;
#(
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  scan_token_t            tok_in,
    output scan_token_t            tok_out,
    input  logic [OFFSET_BITS-1:0] key,
    input  commit_t                cmd,
    input  logic [OFFSET_BITS-1:0] wr_offset,
    input  logic [SIZE_W-1:0]      wr_size
);

    logic                   valid_reg;
    logic [OFFSET_BITS-1:0] offset_reg;
    logic [SIZE_W-1:0]      size_reg;
    logic                   claim_mark_reg;
    logic                   match_mark_reg;
    scan_token_t            tok_reg;
    scan_token_t            tok_next;
    logic                   hit;
    logic                   is_free_pick;

    // A slot is picked for a claim only when it is the first free one the token meets.
    assign hit          = valid_reg && (offset_reg == key);
    assign is_free_pick = !valid_reg && !tok_in.free_seen;

    always_comb
    begin
        tok_next            = tok_in;
        tok_next.free_seen  = tok_in.free_seen | ~valid_reg;
        tok_next.match_seen = tok_in.match_seen | hit;
        if (hit && !tok_in.match_seen)
        begin
            tok_next.match_size = size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= 1'b0;
            claim_mark_reg <= 1'b0;
            match_mark_reg <= 1'b0;
            tok_reg        <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (tok_in.live)
            begin
                claim_mark_reg <= is_free_pick;
                match_mark_reg <= hit && !tok_in.match_seen;
            end
            if (cmd.claim && claim_mark_reg)
            begin
                valid_reg <= 1'b1;
            end
            else if (cmd.drop && match_mark_reg)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.claim && claim_mark_reg)
        begin
            offset_reg <= wr_offset;
            size_reg   <= wr_size;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== sv/bump_allocator_with_entry_table_unit.sv =====
// Bump allocator with a table of ENTRIES block slots.
// Requests arrive on the in channel (in_valid, in_stall): opcode, request_size,
// pointer_present and pointer_offset. Each accepted beat produces exactly one
// beat on the out channel (out_valid, out_stall): status, result_present,
// result_offset and copy_length.
// Each request sends a scan token along the row of slot cells, one cell per
// cycle; the token collects the first free slot and the slot whose offset
// matches. The decision is then broadcast to all marked cells together.
// A request passes through the launch register, the slot chain and the decide
// state, so the slot chain length sets its time to a result; the next request
// is taken only once the result is in the output register. The result sits
// there; a stalled receiver holds it and the following request is scanned but
// waits for that register to empty. Reset empties every slot, clears the heap
// top and the last error, sets the heap size to 32768 and leaves no result
// pending. The heap size is written through cfg_wr_en and cfg_wr_data; the user
// must do so only while no request is in flight; the block does not enforce it.
module bump_allocator_with_entry_table_unit
    import bael_pkg::*;
#(
    parameter int unsigned ENTRIES     = 32,
    parameter int unsigned OFFSET_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SIZE_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        opcode,
    input  logic [SIZE_W-1:0] request_size,
    input  logic              pointer_present,
    input  logic [SIZE_W-1:0] pointer_offset,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        status,
    output logic              result_present,
    output logic [SIZE_W-1:0] result_offset,
    output logic [SIZE_W-1:0] copy_length
);

    localparam int unsigned CMP_W = ((OFFSET_BITS > SIZE_W + 1) ? OFFSET_BITS : SIZE_W + 1) + 1;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SIZE_W-1:0]      heap_size_reg;
    logic [OFFSET_BITS-1:0] heap_top_reg;
    logic [OFFSET_BITS-1:0] heap_top_next;
    err_t                   last_error_reg;
    err_t                   err_next;
    op_t                    opcode_reg;
    logic [SIZE_W-1:0]      req_reg;
    logic                   present_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic                   launch_reg;
    logic                   scan_free_reg;
    logic                   scan_match_reg;
    logic [SIZE_W-1:0]      scan_size_reg;
    logic                   out_valid_reg;
    err_t                   status_reg;
    logic                   res_present_reg;
    logic [OFFSET_BITS-1:0] res_offset_reg;
    logic [SIZE_W-1:0]      copy_reg;
    logic                   res_present_next;
    logic [OFFSET_BITS-1:0] res_offset_next;
    logic [SIZE_W-1:0]      copy_next;
    commit_t                decision;
    commit_t                cell_cmd;
    logic                   in_fire;
    logic                   go;
    logic [CMP_W-1:0]       ptr_w;
    logic [CMP_W-1:0]       res_w;
    logic [CMP_W-1:0]       sz_w;
    logic [CMP_W-1:0]       sum_w;
    err_t                   alloc_err;
    logic                   do_alloc;
    logic                   do_free;
    logic                   grow;
    scan_token_t            tok [0:ENTRIES];

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign go       = (state_reg == ST_DECIDE) && (!out_valid_reg || !out_stall);
    assign ptr_w    = CMP_W'(pointer_offset);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_size_reg <= HEAP_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            heap_size_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (tok[ENTRIES].live)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        sz_w             = CMP_W'(req_reg) + CMP_W'(req_reg[0]);
        sum_w            = CMP_W'(heap_top_reg) + sz_w;
        decision         = '0;
        err_next         = last_error_reg;
        res_present_next = 1'b0;
        res_offset_next  = '0;
        copy_next        = '0;
        heap_top_next    = heap_top_reg;
        do_alloc         = 1'b0;
        do_free          = 1'b0;
        grow             = 1'b0;
        if (req_reg == '0)
        begin
            alloc_err = ERR_ZERO_SIZE;
        end
        else if (sum_w > CMP_W'(heap_size_reg))
        begin
            alloc_err = ERR_HEAP_EXHAUSTED;
        end
        else if (!scan_free_reg)
        begin
            alloc_err = ERR_NO_SLOT;
        end
        else
        begin
            alloc_err = ERR_OK;
        end
        case (opcode_reg)
            OP_ALLOC:
            begin
                do_alloc = 1'b1;
            end
            OP_FREE:
            begin
                do_free = present_reg;
            end
            OP_REALLOC:
            begin
                if (!present_reg)
                begin
                    do_alloc = 1'b1;
                end
                else if (req_reg == '0)
                begin
                    do_free = 1'b1;
                end
                else if (!scan_match_reg)
                begin
                    err_next = ERR_REALLOC_NOT_FOUND;
                end
                else if (req_reg <= scan_size_reg)
                begin
                    err_next         = ERR_OK;
                    res_present_next = 1'b1;
                    res_offset_next  = off_reg;
                end
                else
                begin
                    do_alloc = 1'b1;
                    grow     = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        if (do_free)
        begin
            if (scan_match_reg)
            begin
                decision.drop = 1'b1;
                err_next      = ERR_OK;
            end
            else
            begin
                err_next = ERR_INVALID_PTR;
            end
        end
        if (do_alloc)
        begin
            err_next = alloc_err;
            if (alloc_err == ERR_OK)
            begin
                decision.claim   = 1'b1;
                res_present_next = 1'b1;
                res_offset_next  = heap_top_reg;
                heap_top_next    = sum_w[OFFSET_BITS-1:0];
                if (grow)
                begin
                    decision.drop = 1'b1;
                    copy_next     = scan_size_reg;
                end
            end
        end
    end

    assign cell_cmd.claim = decision.claim & go;
    assign cell_cmd.drop  = decision.drop & go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            heap_top_reg   <= '0;
            last_error_reg <= ERR_OK;
            launch_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= in_fire;
            if (go)
            begin
                heap_top_reg   <= heap_top_next;
                last_error_reg <= err_next;
                out_valid_reg  <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            opcode_reg  <= op_t'(opcode);
            req_reg     <= request_size;
            present_reg <= pointer_present;
            off_reg     <= ptr_w[OFFSET_BITS-1:0];
        end
        if ((state_reg == ST_SCAN) && tok[ENTRIES].live)
        begin
            scan_free_reg  <= tok[ENTRIES].free_seen;
            scan_match_reg <= tok[ENTRIES].match_seen;
            scan_size_reg  <= tok[ENTRIES].match_size;
        end
        if (go)
        begin
            status_reg      <= err_next;
            res_present_reg <= res_present_next;
            res_offset_reg  <= res_offset_next;
            copy_reg        <= copy_next;
        end
    end

    assign tok[0] = '{live: launch_reg, default: '0};

    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        bael_cell #(
            .OFFSET_BITS(OFFSET_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .tok_in   (tok[i]),
            .tok_out  (tok[i+1]),
            .key      (off_reg),
            .cmd      (cell_cmd),
            .wr_offset(heap_top_reg),
            .wr_size  (sz_w[SIZE_W-1:0])
        );
    end

    assign res_w          = CMP_W'(res_offset_reg);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign result_present = res_present_reg;
    assign result_offset  = res_w[SIZE_W-1:0];
    assign copy_length    = copy_reg;

`ifndef ASSERT_OFF
    a_token_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tok[ENTRIES].live |-> (state_reg == ST_SCAN))
        else $error("scan token left the chain outside the scan state");

    a_top_moves_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(heap_top_reg) |-> ($past(state_reg) == ST_DECIDE))
        else $error("heap top changed outside a commit");

    a_claim_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        cell_cmd.claim |-> scan_free_reg)
        else $error("slot claimed although the scan found none free");

    a_drop_needs_match: assert property (@(posedge clk) disable iff (!rst_n)
        cell_cmd.drop |-> scan_match_reg)
        else $error("slot freed although the scan found no match");

    a_result_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_present) |-> (status == ERR_OK))
        else $error("block returned together with an error status");
`endif

endmodule
